// File: sv/pgphdr_pkg.sv
// ----------------------------------------------------------------------------
// pgphdr_pkg
// Shared types and codes for the packet header encoder: request and result
// payloads, the encoded header passed from front end to back end, and the
// length form and error codes.
// ----------------------------------------------------------------------------
package pgphdr_pkg;

  // Length form codes of a request
  localparam logic [2:0] FORM_AUTO    = 3'd0;
  localparam logic [2:0] FORM_ONE     = 3'd1;
  localparam logic [2:0] FORM_TWO     = 3'd2;
  localparam logic [2:0] FORM_FOUR    = 3'd3;
  localparam logic [2:0] FORM_PARTIAL = 3'd4;

  // Error codes of a result
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_TAG         = 3'd1;
  localparam logic [2:0] ERR_MISFIT      = 3'd2;
  localparam logic [2:0] ERR_INDET       = 3'd3;
  localparam logic [2:0] ERR_PARTIAL     = 3'd4;
  localparam logic [2:0] ERR_OLD_PARTIAL = 3'd5;

  // Longest header in bytes and the index width over it
  localparam int unsigned HDR_BYTES = 6;
  localparam int unsigned IDX_W     = 3;

  // One header request
  typedef struct packed {
    logic        header_format;
    logic [5:0]  packet_tag;
    logic [31:0] body_length;
    logic [2:0]  length_form;
  } req_t;

  // One result byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [2:0] error_code;
  } res_t;

  // One fully encoded header; an error is a single zero byte
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]          last_idx;
    logic [2:0]                error_code;
  } job_t;

endpackage

// File: sv/pgphdr_front.sv
// ----------------------------------------------------------------------------
// pgphdr_front
// Classifies a header request and builds its complete byte string, its last
// byte index and its error code in one pass of logic.
// ----------------------------------------------------------------------------
module pgphdr_front (
  input  pgphdr_pkg::req_t req,
  output pgphdr_pkg::job_t job
);

  logic [31:0] len;
  logic [5:0]  tag;
  logic [2:0]  form;
  logic [2:0]  eff_form;
  logic [7:0]  head;
  logic [12:0] adj;
  logic [13:0] adj_full;
  logic        pow2_ok;
  logic [4:0]  log2_len;

  assign len  = req.body_length;
  assign tag  = req.packet_tag;
  assign form = req.length_form;

  // Offset for the new-format two-octet length
  assign adj_full = len[13:0] - 14'd192;
  assign adj      = adj_full[12:0];

  // Accept a single set bit in 1..2^30 as a partial chunk size
  assign pow2_ok = (len != 32'd0) && ((len & (len - 32'd1)) == 32'd0) && !len[31];

  // Turn the single set bit into its position
  always_comb begin
    log2_len = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (len[i]) begin
        log2_len = log2_len | 5'(i);
      end
    end
  end

  // Build the header or the error result
  always_comb begin
    job      = '0;
    eff_form = form;
    head     = 8'h00;
    if (!req.header_format) begin
      if (tag[5:4] != 2'b00) begin
        job.error_code = pgphdr_pkg::ERR_TAG;
      end else if (form == pgphdr_pkg::FORM_PARTIAL) begin
        job.error_code = pgphdr_pkg::ERR_OLD_PARTIAL;
      end else if (form > pgphdr_pkg::FORM_PARTIAL) begin
        job.error_code = pgphdr_pkg::ERR_INDET;
      end else begin
        if (form == pgphdr_pkg::FORM_AUTO) begin
          eff_form = (len <= 32'hff)   ? pgphdr_pkg::FORM_ONE :
                     (len <= 32'hffff) ? pgphdr_pkg::FORM_TWO : pgphdr_pkg::FORM_FOUR;
        end
        head = {2'b10, tag[3:0], 2'b00};
        unique case (eff_form)
          pgphdr_pkg::FORM_ONE: begin
            if (len > 32'hff) begin
              job.error_code = pgphdr_pkg::ERR_MISFIT;
            end else begin
              job.bytes[0] = head;
              job.bytes[1] = len[7:0];
              job.last_idx = 3'd1;
            end
          end
          pgphdr_pkg::FORM_TWO: begin
            if (len > 32'hffff) begin
              job.error_code = pgphdr_pkg::ERR_MISFIT;
            end else begin
              job.bytes[0] = head | 8'h01;
              job.bytes[1] = len[15:8];
              job.bytes[2] = len[7:0];
              job.last_idx = 3'd2;
            end
          end
          default: begin
            job.bytes[0] = head | 8'h02;
            job.bytes[1] = len[31:24];
            job.bytes[2] = len[23:16];
            job.bytes[3] = len[15:8];
            job.bytes[4] = len[7:0];
            job.last_idx = 3'd4;
          end
        endcase
      end
    end else begin
      if (form > pgphdr_pkg::FORM_PARTIAL) begin
        job.error_code = pgphdr_pkg::ERR_INDET;
      end else begin
        if (form == pgphdr_pkg::FORM_AUTO) begin
          eff_form = (len <= 32'hbf)   ? pgphdr_pkg::FORM_ONE :
                     (len <= 32'h20bf) ? pgphdr_pkg::FORM_TWO : pgphdr_pkg::FORM_FOUR;
        end
        head = {2'b11, tag};
        unique case (eff_form)
          pgphdr_pkg::FORM_ONE: begin
            if (len > 32'hbf) begin
              job.error_code = pgphdr_pkg::ERR_MISFIT;
            end else begin
              job.bytes[0] = head;
              job.bytes[1] = len[7:0];
              job.last_idx = 3'd1;
            end
          end
          pgphdr_pkg::FORM_TWO: begin
            if ((len < 32'hc0) || (len > 32'h20bf)) begin
              job.error_code = pgphdr_pkg::ERR_MISFIT;
            end else begin
              job.bytes[0] = head;
              job.bytes[1] = {3'b110, adj[12:8]};
              job.bytes[2] = adj[7:0];
              job.last_idx = 3'd2;
            end
          end
          pgphdr_pkg::FORM_PARTIAL: begin
            if (!pow2_ok) begin
              job.error_code = pgphdr_pkg::ERR_PARTIAL;
            end else begin
              job.bytes[0] = head;
              job.bytes[1] = {3'b111, log2_len};
              job.last_idx = 3'd1;
            end
          end
          default: begin
            job.bytes[0] = head;
            job.bytes[1] = 8'hff;
            job.bytes[2] = len[31:24];
            job.bytes[3] = len[23:16];
            job.bytes[4] = len[15:8];
            job.bytes[5] = len[7:0];
            job.last_idx = 3'd5;
          end
        endcase
      end
    end
  end

endmodule

// File: sv/pgphdr_queue.sv
// ----------------------------------------------------------------------------
// pgphdr_queue
// Short first-in first-out queue of encoded headers between the front end
// and the back end.
// ----------------------------------------------------------------------------
module pgphdr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  pgphdr_pkg::job_t wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output pgphdr_pkg::job_t rd_data,
  output logic             q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pgphdr_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_FULL);
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  // Store an entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/pgphdr_back.sv
// ----------------------------------------------------------------------------
// pgphdr_back
// Holds one encoded header and hands out its bytes one per pop, loading the
// next header from the queue as the last byte leaves.
// ----------------------------------------------------------------------------
module pgphdr_back (
  input  logic             clk,
  input  logic             rst,
  input  pgphdr_pkg::job_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output pgphdr_pkg::res_t res,
  output logic             empty,
  input  logic             pop
);

  pgphdr_pkg::job_t               cur;
  logic [pgphdr_pkg::IDX_W-1:0]   idx;
  logic                           busy;
  logic                           at_last;
  logic                           take;

  assign at_last = (idx == cur.last_idx);
  assign take    = pop && busy;
  assign q_pop   = (!busy || (take && at_last)) && !q_empty;
  assign empty   = !busy;

  // Present the current byte
  assign res.out_byte   = cur.bytes[idx];
  assign res.last_byte  = at_last;
  assign res.error_code = cur.error_code;

  // Hold the header payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // Advance through the bytes of the current header
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

// File: sv/openpgp_packet_header_encoder_top.sv
// ----------------------------------------------------------------------------
// openpgp_packet_header_encoder_top
// Packet header encoder: turns one header request into its header bytes,
// one byte per result, or into a single error result.
//
//   Channel   Handshake      Payload   Moves
//   request   push / full    req       format, tag, body length, length form
//   result    pop / empty    res       header byte, last flag, error code
//
// Each request is encoded in the cycle it is accepted and queued; it costs
// no further front-end time, so requests are taken every cycle until the
// queue is full. The back end gives one byte per cycle while pop is high,
// so a header of n bytes (1 for an error, 2 to 6 otherwise) takes n pops.
// Synchronous reset empties the queue and the back end. A stalled result port
// stops only the back end; requests keep entering the queue until it is full.
// ----------------------------------------------------------------------------
module openpgp_packet_header_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pgphdr_pkg::req_t req,
  input  logic             pop,
  output logic             empty,
  output pgphdr_pkg::res_t res
);

  pgphdr_pkg::job_t enc_job;
  pgphdr_pkg::job_t q_data;
  logic             q_empty;
  logic             q_pop;

  // Encode the incoming request
  pgphdr_front u_front (
    .req (req),
    .job (enc_job)
  );

  // Buffer encoded headers
  pgphdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (enc_job),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  // Serialize header bytes
  pgphdr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

// File: bench/openpgp_packet_header_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// openpgp_packet_header_encoder_top_tb
// Self-checking bench for the packet header encoder. Each accepted request
// is encoded by a local predictor into the header bytes it should produce,
// or into a single error byte. Every result byte popped from the block is
// compared with the oldest predicted one. Directed corner requests come
// first, then random requests in four idling phases. One long result-side
// hold fills the block and stalls its request side.
// ----------------------------------------------------------------------------
module openpgp_packet_header_encoder_top_tb;

  // Predicts the header bytes of each request and checks them against results
  class header_checker;
    pgphdr_pkg::res_t expected_bytes[$];
    int   errors;
    int   requests_seen;
    int   error_requests;
    int   bytes_checked;

    function new();
      errors = 0;
      requests_seen = 0;
      error_requests = 0;
      bytes_checked = 0;
    endfunction

    // Encode one accepted request and queue its result bytes
    function void note_request(pgphdr_pkg::req_t r);
      logic [7:0]       hdr[6];
      int               n;
      int               e;
      logic [2:0]       err;
      logic [2:0]       form;
      logic [31:0]      len;
      logic [31:0]      adj;
      pgphdr_pkg::res_t item;
      err = pgphdr_pkg::ERR_NONE;
      n = 0;
      form = r.length_form;
      len = r.body_length;
      foreach (hdr[k]) hdr[k] = 8'h00;
      if (!r.header_format) begin
        // Old format: tag check comes before anything else
        if (r.packet_tag >= 6'd16) err = pgphdr_pkg::ERR_TAG;
        else if (form == pgphdr_pkg::FORM_PARTIAL) err = pgphdr_pkg::ERR_OLD_PARTIAL;
        else if (form > pgphdr_pkg::FORM_PARTIAL) err = pgphdr_pkg::ERR_INDET;
        else begin
          if (form == pgphdr_pkg::FORM_AUTO)
            form = (len <= 32'hff)   ? pgphdr_pkg::FORM_ONE :
                   (len <= 32'hffff) ? pgphdr_pkg::FORM_TWO : pgphdr_pkg::FORM_FOUR;
          hdr[0] = {2'b10, r.packet_tag[3:0], 2'b00};
          case (form)
            pgphdr_pkg::FORM_ONE: begin
              if (len > 32'hff) err = pgphdr_pkg::ERR_MISFIT;
              else begin
                hdr[1] = len[7:0];
                n = 2;
              end
            end
            pgphdr_pkg::FORM_TWO: begin
              if (len > 32'hffff) err = pgphdr_pkg::ERR_MISFIT;
              else begin
                hdr[0][0] = 1'b1;
                hdr[1] = len[15:8];
                hdr[2] = len[7:0];
                n = 3;
              end
            end
            default: begin
              hdr[0][1] = 1'b1;
              {hdr[1], hdr[2], hdr[3], hdr[4]} = len;
              n = 5;
            end
          endcase
        end
      end else begin
        // New format: any tag fits in the low six bits
        if (form > pgphdr_pkg::FORM_PARTIAL) err = pgphdr_pkg::ERR_INDET;
        else begin
          if (form == pgphdr_pkg::FORM_AUTO)
            form = (len <= 32'hbf)   ? pgphdr_pkg::FORM_ONE :
                   (len <= 32'h20bf) ? pgphdr_pkg::FORM_TWO : pgphdr_pkg::FORM_FOUR;
          hdr[0] = {2'b11, r.packet_tag};
          case (form)
            pgphdr_pkg::FORM_ONE: begin
              if (len > 32'hbf) err = pgphdr_pkg::ERR_MISFIT;
              else begin
                hdr[1] = len[7:0];
                n = 2;
              end
            end
            pgphdr_pkg::FORM_TWO: begin
              if (len < 32'hc0 || len > 32'h20bf) err = pgphdr_pkg::ERR_MISFIT;
              else begin
                adj = len - 32'd192;
                hdr[1] = {3'b110, adj[12:8]};
                hdr[2] = adj[7:0];
                n = 3;
              end
            end
            pgphdr_pkg::FORM_PARTIAL: begin
              // Chunk size must be a power of two no larger than 2^30
              if (len == 32'd0 || (len & (len - 32'd1)) != 32'd0 || len[31])
                err = pgphdr_pkg::ERR_PARTIAL;
              else begin
                e = 0;
                while (!len[e]) e++;
                hdr[1] = 8'he0 + 8'(e);
                n = 2;
              end
            end
            default: begin
              hdr[1] = 8'hff;
              {hdr[2], hdr[3], hdr[4], hdr[5]} = len;
              n = 6;
            end
          endcase
        end
      end
      requests_seen++;
      if (err != pgphdr_pkg::ERR_NONE) begin
        error_requests++;
        item.out_byte = 8'h00;
        item.last_byte = 1'b1;
        item.error_code = err;
        expected_bytes.push_back(item);
      end else begin
        for (int k = 0; k < n; k++) begin
          item.out_byte = hdr[k];
          item.last_byte = (k == n - 1);
          item.error_code = pgphdr_pkg::ERR_NONE;
          expected_bytes.push_back(item);
        end
      end
    endfunction

    // Compare one popped result with the oldest predicted byte
    function void check_byte(pgphdr_pkg::res_t got);
      pgphdr_pkg::res_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h last_byte %0b error_code %0d",
               got.out_byte, got.last_byte, got.error_code);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
        errors++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic push;
  logic full;
  pgphdr_pkg::req_t req;
  logic pop;
  logic empty;
  pgphdr_pkg::res_t res;

  header_checker hdr_chk;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int full_waits;

  openpgp_packet_header_encoder_top DUT (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .pop   (pop),
    .empty (empty),
    .res   (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pgphdr_pkg::req_t make_req(logic fmt, logic [5:0] tag,
                                                logic [31:0] len, logic [2:0] form);
    pgphdr_pkg::req_t r;
    r.header_format = fmt;
    r.packet_tag = tag;
    r.body_length = len;
    r.length_form = form;
    return r;
  endfunction

  // Draw a request biased toward encodable headers and length boundaries
  function automatic pgphdr_pkg::req_t random_req();
    logic       fmt;
    logic [5:0] tag;
    logic [2:0] form;
    logic [31:0] len;
    int w;
    fmt = 1'($urandom_range(1, 0));
    if (!fmt && $urandom_range(99, 0) < 85) tag = 6'($urandom_range(15, 0));
    else tag = 6'($urandom_range(63, 0));
    w = $urandom_range(99, 0);
    if (w < 30) form = pgphdr_pkg::FORM_AUTO;
    else if (w < 45) form = pgphdr_pkg::FORM_ONE;
    else if (w < 60) form = pgphdr_pkg::FORM_TWO;
    else if (w < 75) form = pgphdr_pkg::FORM_FOUR;
    else if (w < 90) form = pgphdr_pkg::FORM_PARTIAL;
    else form = 3'($urandom_range(7, 5));
    if (form == pgphdr_pkg::FORM_PARTIAL && $urandom_range(3, 0) != 0)
      len = 32'h1 << $urandom_range(31, 0);
    else begin
      case ($urandom_range(6, 0))
        0: len = $urandom_range(255, 0);
        1: len = $urandom_range(32'h2100, 0);
        2: len = $urandom_range(32'h1ffff, 0);
        3: len = $urandom();
        4: len = 32'h1 << $urandom_range(31, 0);
        5: len = (32'h1 << $urandom_range(31, 0)) | (32'h1 << $urandom_range(31, 0));
        default: begin
          case ($urandom_range(9, 0))
            0: len = 32'h0;
            1: len = 32'hbf;
            2: len = 32'hc0;
            3: len = 32'hff;
            4: len = 32'h100;
            5: len = 32'h20bf;
            6: len = 32'h20c0;
            7: len = 32'hffff;
            8: len = 32'h10000;
            default: len = 32'hffffffff;
          endcase
        end
      endcase
    end
    return make_req(fmt, tag, len, form);
  endfunction

  // Offer one request, with random idle cycles ahead of it, until accepted
  task automatic send_request(pgphdr_pkg::req_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) begin
      full_waits++;
      @(posedge clk);
    end
    hdr_chk.note_request(r);
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(random_req());
  endtask

  // Result side: check accepted bytes, then choose pop for the next edge
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && empty === 1'b0) hdr_chk.check_byte(res);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (rst) pop <= 1'b0;
      else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else pop <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    hdr_chk = new();
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    req = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    full_waits = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: old format
    send_request(make_req(1'b0, 6'd0, 32'h0, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b0, 6'd15, 32'hff, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b0, 6'd5, 32'h100, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b0, 6'd10, 32'hffff, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b0, 6'd3, 32'h10000, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b0, 6'd15, 32'hffffffff, pgphdr_pkg::FORM_FOUR));
    send_request(make_req(1'b0, 6'd16, 32'h1, pgphdr_pkg::FORM_ONE));
    send_request(make_req(1'b0, 6'd63, 32'h0, pgphdr_pkg::FORM_PARTIAL));
    send_request(make_req(1'b0, 6'd1, 32'h100, pgphdr_pkg::FORM_ONE));
    send_request(make_req(1'b0, 6'd2, 32'h10000, pgphdr_pkg::FORM_TWO));
    send_request(make_req(1'b0, 6'd4, 32'h8, pgphdr_pkg::FORM_PARTIAL));
    send_request(make_req(1'b0, 6'd6, 32'h8, 3'd5));
    send_request(make_req(1'b0, 6'd7, 32'h8, 3'd6));
    // Directed corners: new format
    send_request(make_req(1'b1, 6'd0, 32'hbf, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b1, 6'd63, 32'hc0, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b1, 6'd17, 32'h20bf, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b1, 6'd42, 32'h20c0, pgphdr_pkg::FORM_AUTO));
    send_request(make_req(1'b1, 6'd11, 32'h0, pgphdr_pkg::FORM_FOUR));
    send_request(make_req(1'b1, 6'd20, 32'hc0, pgphdr_pkg::FORM_ONE));
    send_request(make_req(1'b1, 6'd21, 32'hbf, pgphdr_pkg::FORM_TWO));
    send_request(make_req(1'b1, 6'd22, 32'h20c0, pgphdr_pkg::FORM_TWO));
    send_request(make_req(1'b1, 6'd23, 32'h1, pgphdr_pkg::FORM_PARTIAL));
    send_request(make_req(1'b1, 6'd24, 32'h40000000, pgphdr_pkg::FORM_PARTIAL));
    send_request(make_req(1'b1, 6'd25, 32'h80000000, pgphdr_pkg::FORM_PARTIAL));
    send_request(make_req(1'b1, 6'd26, 32'h0, pgphdr_pkg::FORM_PARTIAL));
    send_request(make_req(1'b1, 6'd27, 32'h3, pgphdr_pkg::FORM_PARTIAL));
    send_request(make_req(1'b1, 6'd28, 32'hffffffff, 3'd7));

    // Free-running phase, with a long result hold to fill the block
    hold_request = 300;
    send_random(80);
    // Sparse requests
    send_idle_pct = 64;
    recv_stall_pct = 0;
    send_random(80);
    // Slow result side
    send_idle_pct = 0;
    recv_stall_pct = 64;
    send_random(80);
    // Light idling on both sides
    send_idle_pct = 18;
    recv_stall_pct = 18;
    send_random(80);
    push <= 1'b0;

    // Drain, then watch for stray results
    while (hdr_chk.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Encoded %0d header requests (%0d rejected with an error code), %0d bytes checked.",
             hdr_chk.requests_seen, hdr_chk.error_requests, hdr_chk.bytes_checked);
    $display("Request side was held off by a full block on %0d cycles.", full_waits);
    if (hdr_chk.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
